// ----- src/ovrs_pkg.sv -----
// ----------------------------------------------------------------------------
// ovrs_pkg
// Shared types and constants of the overvoltage relay sequencer: payload
// words, register file layout and phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ovrs_pkg;

   // register file layout
   localparam int RegCount   = 7;
   localparam int AddrWidth  = 5;
   localparam int DataWidth  = 32;

   typedef enum logic [2:0] {
      REG_DEBOUNCE    = 3'd0,
      REG_SETTLE      = 3'd1,
      REG_CONFIRM     = 3'd2,
      REG_RELAY_GAP   = 3'd3,
      REG_RELAY_PULSE = 3'd4,
      REG_BLINK_HALF  = 3'd5,
      REG_BLINK_COUNT = 3'd6
   } reg_index_type;

   // reset values of the registers
   localparam logic [9:0]  DebounceReset    = 10'd200;
   localparam logic [15:0] SettleReset      = 16'd3000;
   localparam logic [7:0]  ConfirmReset     = 8'd2;
   localparam logic [7:0]  RelayGapReset    = 8'd3;
   localparam logic [11:0] RelayPulseReset  = 12'd300;
   localparam logic [11:0] BlinkHalfReset   = 12'd1000;
   localparam logic [3:0]  BlinkCountReset  = 4'd5;

   localparam logic [15:0] TimerMax = 16'hFFFF;

   typedef enum logic [3:0] {
      PH_WIN1     = 4'd0,
      PH_SETTLE   = 4'd1,
      PH_WIN2     = 4'd2,
      PH_ON_A     = 4'd3,
      PH_ON_B     = 4'd4,
      PH_ON_C     = 4'd5,
      PH_RUN      = 4'd6,
      PH_CONF_V   = 4'd7,
      PH_CONF_O   = 4'd8,
      PH_OFFPULSE = 4'd9,
      PH_BLINK    = 4'd10
   } phase_type;

   typedef struct packed {
      logic       v_sense;
      logic       out_sense;
   } req_word_type;

   typedef struct packed {
      logic       relay_on_drive;
      logic       relay_off_drive;
      logic       led_high_voltage;
      logic       powered;
   } rsp_word_type;

   // register values as seen by the sequencer
   typedef struct packed {
      logic [9:0]  debounce_ticks;
      logic [15:0] settle_ticks;
      logic [7:0]  confirm_ticks;
      logic [7:0]  relay_gap_ticks;
      logic [11:0] relay_pulse_ticks;
      logic [11:0] blink_half_ticks;
      logic [3:0]  blink_count;
   } cfg_type;

endpackage

`default_nettype wire

// ----- src/ovrs_csr.sv -----
// ----------------------------------------------------------------------------
// ovrs_csr
// Register file behind the APB-style port; one word per register at 4*index.
// ----------------------------------------------------------------------------
`default_nettype none

module ovrs_csr
   import ovrs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [AddrWidth-1:0] csr_paddr,
   input  wire logic [DataWidth-1:0] csr_pwdata,
   output logic      [DataWidth-1:0] csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   // write one register, masked to its width; unused index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks    <= DebounceReset;
         cfg_ff.settle_ticks      <= SettleReset;
         cfg_ff.confirm_ticks     <= ConfirmReset;
         cfg_ff.relay_gap_ticks   <= RelayGapReset;
         cfg_ff.relay_pulse_ticks <= RelayPulseReset;
         cfg_ff.blink_half_ticks  <= BlinkHalfReset;
         cfg_ff.blink_count       <= BlinkCountReset;
      end else if (wr_en) begin
         case (idx)
            REG_DEBOUNCE:    cfg_ff.debounce_ticks    <= csr_pwdata[9:0];
            REG_SETTLE:      cfg_ff.settle_ticks      <= csr_pwdata[15:0];
            REG_CONFIRM:     cfg_ff.confirm_ticks     <= csr_pwdata[7:0];
            REG_RELAY_GAP:   cfg_ff.relay_gap_ticks   <= csr_pwdata[7:0];
            REG_RELAY_PULSE: cfg_ff.relay_pulse_ticks <= csr_pwdata[11:0];
            REG_BLINK_HALF:  cfg_ff.blink_half_ticks  <= csr_pwdata[11:0];
            REG_BLINK_COUNT: cfg_ff.blink_count       <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   // read back, zero extended
   always_comb begin
      case (idx)
         REG_DEBOUNCE:    csr_prdata = {22'd0, cfg_ff.debounce_ticks};
         REG_SETTLE:      csr_prdata = {16'd0, cfg_ff.settle_ticks};
         REG_CONFIRM:     csr_prdata = {24'd0, cfg_ff.confirm_ticks};
         REG_RELAY_GAP:   csr_prdata = {24'd0, cfg_ff.relay_gap_ticks};
         REG_RELAY_PULSE: csr_prdata = {20'd0, cfg_ff.relay_pulse_ticks};
         REG_BLINK_HALF:  csr_prdata = {20'd0, cfg_ff.blink_half_ticks};
         REG_BLINK_COUNT: csr_prdata = {28'd0, cfg_ff.blink_count};
         default:         csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/ovrs_core.sv -----
// ----------------------------------------------------------------------------
// ovrs_core
// Phase register, tick timer and output levels; one tick per accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module ovrs_core
   import ovrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_word_type req,
   input  wire cfg_type      cfg,
   output rsp_word_type      rsp
);

   phase_type   phase_ff,  phase_in;
   logic [15:0] timer_ff,  timer_in;
   logic [4:0]  blinks_ff, blinks_in;
   logic        on_ff,  on_in;
   logic        off_ff, off_in;
   logic        led_ff, led_in;
   logic        pwr_ff, pwr_in;

   logic [15:0] timer_inc;
   logic [15:0] len_raw;
   logic [15:0] len_eff;
   logic        done;
   logic        vhi;
   logic        olo;

   assign vhi = req.v_sense;
   assign olo = !req.out_sense;

   // saturating tick count
   assign timer_inc = (phase_ff == PH_WIN1 || phase_ff == PH_SETTLE ||
                       phase_ff == PH_WIN2 || phase_ff == PH_ON_A ||
                       phase_ff == PH_ON_B || phase_ff == PH_ON_C ||
                       phase_ff == PH_RUN || phase_ff == PH_CONF_V ||
                       phase_ff == PH_CONF_O || phase_ff == PH_OFFPULSE ||
                       phase_ff == PH_BLINK)
                      ? ((timer_ff != TimerMax) ? timer_ff + 16'd1 : timer_ff)
                      : 16'd1;

   // pick the delay length of the current phase
   always_comb begin
      case (phase_ff)
         PH_SETTLE:           len_raw = cfg.settle_ticks;
         PH_ON_A, PH_ON_B:    len_raw = {8'd0, cfg.relay_gap_ticks};
         PH_ON_C, PH_OFFPULSE: len_raw = {4'd0, cfg.relay_pulse_ticks};
         PH_CONF_V, PH_CONF_O: len_raw = {8'd0, cfg.confirm_ticks};
         PH_BLINK:            len_raw = {4'd0, cfg.blink_half_ticks};
         default:             len_raw = {6'd0, cfg.debounce_ticks};
      endcase
   end

   // a zero delay counts as one tick
   assign len_eff = (len_raw == 16'd0) ? 16'd1 : len_raw;
   assign done    = timer_inc >= len_eff;

   // next state for one tick
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_inc;
      blinks_in = blinks_ff;
      on_in     = on_ff;
      off_in    = off_ff;
      led_in    = led_ff;
      pwr_in    = pwr_ff;
      case (phase_ff)
         PH_SETTLE: begin
            led_in = 1'b1;
            if (done) begin
               phase_in = PH_WIN2;
               timer_in = '0;
            end
         end
         PH_WIN2: begin
            led_in = 1'b1;
            if (vhi) begin
               phase_in = PH_WIN1;
               timer_in = '0;
            end else if (done) begin
               off_in   = 1'b1;
               phase_in = PH_ON_A;
               timer_in = '0;
            end else begin
               timer_in = timer_inc;
            end
         end
         PH_ON_A: begin
            if (done) begin
               on_in    = 1'b1;
               phase_in = PH_ON_B;
               timer_in = '0;
            end
         end
         PH_ON_B: begin
            if (done) begin
               off_in   = 1'b0;
               phase_in = PH_ON_C;
               timer_in = '0;
            end
         end
         PH_ON_C: begin
            if (done) begin
               on_in    = 1'b0;
               led_in   = 1'b0;
               pwr_in   = 1'b1;
               phase_in = PH_RUN;
               timer_in = '0;
            end
         end
         PH_RUN: begin
            // no delay here: hold the timer
            timer_in = timer_ff;
            if (vhi) begin
               phase_in = PH_CONF_V;
               timer_in = '0;
            end else if (olo) begin
               phase_in = PH_CONF_O;
               timer_in = '0;
            end
         end
         PH_CONF_V: begin
            if (done) begin
               timer_in = '0;
               if (vhi) begin
                  off_in   = 1'b1;
                  pwr_in   = 1'b0;
                  phase_in = PH_OFFPULSE;
               end else if (olo) begin
                  phase_in = PH_CONF_O;
               end else begin
                  phase_in = PH_RUN;
               end
            end
         end
         PH_CONF_O: begin
            if (done) begin
               timer_in = '0;
               if (olo) begin
                  phase_in = PH_WIN1;
                  led_in   = 1'b1;
                  pwr_in   = 1'b0;
               end else begin
                  phase_in = PH_RUN;
               end
            end
         end
         PH_OFFPULSE: begin
            if (done) begin
               off_in    = 1'b0;
               led_in    = 1'b1;
               blinks_in = {cfg.blink_count, 1'b0};
               timer_in  = '0;
               if (cfg.blink_count == 4'd0) begin
                  phase_in = PH_WIN1;
                  pwr_in   = 1'b0;
               end else begin
                  phase_in = PH_BLINK;
               end
            end
         end
         PH_BLINK: begin
            if (done) begin
               led_in   = !led_ff;
               timer_in = '0;
               if (blinks_ff != 5'd0) begin
                  blinks_in = blinks_ff - 5'd1;
               end
               if (blinks_ff <= 5'd1) begin
                  phase_in = PH_WIN1;
                  led_in   = 1'b1;
                  pwr_in   = 1'b0;
               end
            end
         end
         default: begin
            // first safe window; unknown codes fall in here too
            phase_in = PH_WIN1;
            led_in   = 1'b1;
            if (vhi) begin
               timer_in = '0;
            end else if (done) begin
               phase_in = PH_SETTLE;
               timer_in = '0;
            end
         end
      endcase
   end

   // advance state on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WIN1;
         timer_ff  <= '0;
         blinks_ff <= '0;
         on_ff     <= 1'b0;
         off_ff    <= 1'b0;
         led_ff    <= 1'b0;
         pwr_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         blinks_ff <= blinks_in;
         on_ff     <= on_in;
         off_ff    <= off_in;
         led_ff    <= led_in;
         pwr_ff    <= pwr_in;
      end
   end

   // levels after this tick
   assign rsp.relay_on_drive   = on_in;
   assign rsp.relay_off_drive  = off_in;
   assign rsp.led_high_voltage = led_in;
   assign rsp.powered          = pwr_in;

endmodule

`default_nettype wire

// ----- src/ovrs_skid.sv -----
// ----------------------------------------------------------------------------
// ovrs_skid
// Result register with one skid entry, so a tick is taken while a result
// still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module ovrs_skid
   import ovrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_word_type push_word,
   output logic              full,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data
);

   logic         out_valid_ff;
   logic         skid_valid_ff;
   rsp_word_type out_ff;
   rsp_word_type skid_ff;
   logic         pop;

   assign pop       = out_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // control: drain skid first, else load output or park in skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= push_word;
         end else begin
            out_ff <= push_word;
         end
      end
   end

endmodule

`default_nettype wire

// ----- src/overvoltage_relay_sequencer.sv -----
// ----------------------------------------------------------------------------
// overvoltage_relay_sequencer
// Tick-driven relay sequencer: safe-voltage windows, latching relay pulses,
// fault confirmation and LED blinking after an overvoltage trip.
// ----------------------------------------------------------------------------
//   channel  direction  word            handshake
//   req_     in         req_word_type   req_valid / req_stall
//   rsp_     out        rsp_word_type   rsp_valid / rsp_stall
//   csr_     in/out     32-bit regs     APB: psel, penable, pwrite, pready
//
// One tick word is taken every cycle while req_stall is low; its result is
// registered. Phase, timer and levels update in one pass from the tick word.
// A one-entry skid lets one more word in while rsp is stalled; req_stall
// rises only when that entry is occupied.
// Synchronous reset restores the register reset values and the first window.
// ----------------------------------------------------------------------------
`default_nettype none

module overvoltage_relay_sequencer
   import ovrs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_word_type         req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_word_type              rsp_data,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [AddrWidth-1:0] csr_paddr,
   input  wire logic [DataWidth-1:0] csr_pwdata,
   output logic      [DataWidth-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type      cfg;
   rsp_word_type result;
   logic         full;
   logic         step;

   assign req_stall = full;
   assign step      = req_valid && !full;

   ovrs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ovrs_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data),
      .cfg   (cfg),
      .rsp   (result)
   );

   ovrs_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_word (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- dv/ovrs_checker.sv -----
// ----------------------------------------------------------------------------
// ovrs_checker
// Scoreboard for the overvoltage relay sequencer. It watches the tick, result
// and register ports, runs its own model of the relay sequence on each tick
// word taken, and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module ovrs_checker
   import ovrs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire req_word_type         req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsp_word_type         rsp_data,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [AddrWidth-1:0] csr_paddr,
   input  wire logic [DataWidth-1:0] csr_pwdata,
   input  wire logic [DataWidth-1:0] csr_prdata,
   input  wire logic                 csr_pready,
   output int                        error_count,
   output int                        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // model copy of registers and sequencer state
   cfg_type      regs;
   phase_type    phase;
   logic [15:0]  phase_timer;
   logic [4:0]   blinks_left;
   logic         relay_on;
   logic         relay_off;
   logic         led;
   logic         powered;

   rsp_word_type expected_levels[$];
   int           errors = 0;

   function automatic void reset_model();
      regs.debounce_ticks    = DebounceReset;
      regs.settle_ticks      = SettleReset;
      regs.confirm_ticks     = ConfirmReset;
      regs.relay_gap_ticks   = RelayGapReset;
      regs.relay_pulse_ticks = RelayPulseReset;
      regs.blink_half_ticks  = BlinkHalfReset;
      regs.blink_count       = BlinkCountReset;
      phase       = PH_WIN1;
      phase_timer = '0;
      blinks_left = '0;
      relay_on    = 1'b0;
      relay_off   = 1'b0;
      led         = 1'b0;
      powered     = 1'b0;
   endfunction

   // register writes keep only the register's own width; unknown indexes drop
   function automatic void write_reg(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
         REG_DEBOUNCE:    regs.debounce_ticks    = data[9:0];
         REG_SETTLE:      regs.settle_ticks      = data[15:0];
         REG_CONFIRM:     regs.confirm_ticks     = data[7:0];
         REG_RELAY_GAP:   regs.relay_gap_ticks   = data[7:0];
         REG_RELAY_PULSE: regs.relay_pulse_ticks = data[11:0];
         REG_BLINK_HALF:  regs.blink_half_ticks  = data[11:0];
         REG_BLINK_COUNT: regs.blink_count       = data[3:0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] read_reg(input logic [2:0] idx);
      case (idx)
         REG_DEBOUNCE:    return 32'(regs.debounce_ticks);
         REG_SETTLE:      return 32'(regs.settle_ticks);
         REG_CONFIRM:     return 32'(regs.confirm_ticks);
         REG_RELAY_GAP:   return 32'(regs.relay_gap_ticks);
         REG_RELAY_PULSE: return 32'(regs.relay_pulse_ticks);
         REG_BLINK_HALF:  return 32'(regs.blink_half_ticks);
         REG_BLINK_COUNT: return 32'(regs.blink_count);
         default:         return '0;
      endcase
   endfunction

   // advance the timer, saturating; a zero length counts as one tick
   function automatic bit delay_elapsed(input logic [15:0] len);
      logic [15:0] span;
      span = (len == '0) ? 16'd1 : len;
      if (phase_timer != TimerMax)
         phase_timer++;
      return phase_timer >= span;
   endfunction

   function automatic void enter_phase(input phase_type next_phase);
      phase       = next_phase;
      phase_timer = '0;
   endfunction

   function automatic void drop_to_off();
      enter_phase(PH_WIN1);
      led     = 1'b1;
      powered = 1'b0;
   endfunction

   // one tick of the relay sequence; returns the output levels after it
   function automatic rsp_word_type relay_seq_tick(input req_word_type tick);
      bit           vhi;
      bit           olo;
      rsp_word_type levels;
      vhi = tick.v_sense;
      olo = !tick.out_sense;
      case (phase)
         PH_SETTLE: begin
            led = 1'b1;
            if (delay_elapsed(regs.settle_ticks))
               enter_phase(PH_WIN2);
         end
         PH_WIN2: begin
            led = 1'b1;
            if (vhi) begin
               enter_phase(PH_WIN1);
            end else if (delay_elapsed(16'(regs.debounce_ticks))) begin
               relay_off = 1'b1;
               enter_phase(PH_ON_A);
            end
         end
         PH_ON_A: begin
            if (delay_elapsed(16'(regs.relay_gap_ticks))) begin
               relay_on = 1'b1;
               enter_phase(PH_ON_B);
            end
         end
         PH_ON_B: begin
            if (delay_elapsed(16'(regs.relay_gap_ticks))) begin
               relay_off = 1'b0;
               enter_phase(PH_ON_C);
            end
         end
         PH_ON_C: begin
            if (delay_elapsed(16'(regs.relay_pulse_ticks))) begin
               relay_on = 1'b0;
               led      = 1'b0;
               powered  = 1'b1;
               enter_phase(PH_RUN);
            end
         end
         PH_RUN: begin
            if (vhi)
               enter_phase(PH_CONF_V);
            else if (olo)
               enter_phase(PH_CONF_O);
         end
         PH_CONF_V: begin
            // overvoltage wins; a lost output is confirmed right after
            if (delay_elapsed(16'(regs.confirm_ticks))) begin
               if (vhi) begin
                  relay_off = 1'b1;
                  powered   = 1'b0;
                  enter_phase(PH_OFFPULSE);
               end else if (olo) begin
                  enter_phase(PH_CONF_O);
               end else begin
                  enter_phase(PH_RUN);
               end
            end
         end
         PH_CONF_O: begin
            if (delay_elapsed(16'(regs.confirm_ticks))) begin
               if (olo)
                  drop_to_off();
               else
                  enter_phase(PH_RUN);
            end
         end
         PH_OFFPULSE: begin
            if (delay_elapsed(16'(regs.relay_pulse_ticks))) begin
               relay_off   = 1'b0;
               led         = 1'b1;
               blinks_left = {regs.blink_count, 1'b0};
               if (blinks_left == '0)
                  drop_to_off();
               else
                  enter_phase(PH_BLINK);
            end
         end
         PH_BLINK: begin
            if (delay_elapsed(16'(regs.blink_half_ticks))) begin
               led = !led;
               if (blinks_left != '0)
                  blinks_left--;
               phase_timer = '0;
               if (blinks_left == '0)
                  drop_to_off();
            end
         end
         default: begin
            // first safe window; stray codes fall back here
            if (phase != PH_WIN1)
               enter_phase(PH_WIN1);
            led = 1'b1;
            if (vhi)
               phase_timer = '0;
            else if (delay_elapsed(16'(regs.debounce_ticks)))
               enter_phase(PH_SETTLE);
         end
      endcase
      levels.relay_on_drive   = relay_on;
      levels.relay_off_drive  = relay_off;
      levels.led_high_voltage = led;
      levels.powered          = powered;
      return levels;
   endfunction

   task automatic note_error(input string msg);
      errors++;
      if (errors <= 10)
         $display("%0t ovrs_checker: %s", $realtime, msg);
   endtask

   task automatic check_level(input string name, input logic want, input logic got);
      if (got !== want)
         note_error($sformatf("%s expected %b got %b", name, want, got));
   endtask

   // watch all three ports at each edge: results first, then new ticks
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         reset_model();
         expected_levels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite)
               write_reg(csr_paddr[4:2], csr_pwdata);
            else if (csr_paddr[4:2] < RegCount && csr_prdata !== read_reg(csr_paddr[4:2]))
               note_error($sformatf("register %0d read expected %0h got %0h",
                                    csr_paddr[4:2], read_reg(csr_paddr[4:2]), csr_prdata));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               note_error($sformatf("result word %b with none expected", rsp_data));
            end else begin
               want = expected_levels.pop_front();
               check_level("relay_on_drive", want.relay_on_drive, rsp_data.relay_on_drive);
               check_level("relay_off_drive", want.relay_off_drive,
                           rsp_data.relay_off_drive);
               check_level("led_high_voltage", want.led_high_voltage,
                           rsp_data.led_high_voltage);
               check_level("powered", want.powered, rsp_data.powered);
            end
         end
         if (req_valid && !req_stall)
            expected_levels.push_back(relay_seq_tick(req_data));
      end
      error_count   <= errors;
      pending_count <= expected_levels.size();
   end

endmodule

`default_nettype wire

// ----- dv/tb_overvoltage_relay_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_overvoltage_relay_sequencer
// Drives tick words and register settings into the relay sequencer: a short
// directed walk through turn-on, both fault paths and the blink tail, then
// random sense patterns under a series of timing settings, with random gaps
// on the tick side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_overvoltage_relay_sequencer;
   import ovrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 300000;
   localparam int PhaseTicks  = 60;
   localparam int PhaseCount  = 8;

   typedef enum int {
      PAT_QUIET,
      PAT_VHIGH,
      PAT_OLOW,
      PAT_BOTH,
      PAT_NOISE
   } pattern_type;

   typedef enum int {
      SET_SMALL,
      SET_ZERO,
      SET_MAX,
      SET_LONG_BLINK,
      SET_FAST
   } setting_type;

   localparam req_word_type QuietTick = '{v_sense: 1'b0, out_sense: 1'b1};
   localparam req_word_type HighTick  = '{v_sense: 1'b1, out_sense: 1'b1};
   localparam req_word_type LostTick  = '{v_sense: 1'b0, out_sense: 1'b0};
   localparam req_word_type BothTick  = '{v_sense: 1'b1, out_sense: 1'b0};

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_word_type         req_data    = QuietTick;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_word_type         rsp_data;
   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [AddrWidth-1:0] csr_paddr   = '0;
   logic [DataWidth-1:0] csr_pwdata  = '0;
   logic [DataWidth-1:0] csr_prdata;
   logic                 csr_pready;

   int          mismatch_total;
   int          words_pending;
   int          cycles      = 0;
   int          stall_left  = 0;
   bit          idling      = 1'b1;
   int          burst_left  = 0;
   pattern_type burst_kind  = PAT_QUIET;

   overvoltage_relay_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ovrs_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .error_count   (mismatch_total),
      .pending_count (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // stall the result side in short bursts with an occasional long one
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idling && $urandom_range(0, 99) < 20) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 2);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("tb_overvoltage_relay_sequencer NOT OK");
         $finish;
      end
   end

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idling || r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(5, 20);
   endfunction

   // hold the word until the block takes it
   task automatic send_tick(input req_word_type word);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_ticks(input req_word_type word, input int count);
      repeat (count) send_tick(word);
   endtask

   // sense patterns: mostly quiet stretches, with fault bursts and noise
   function automatic req_word_type next_sense_word();
      int r;
      if (burst_left == 0) begin
         r = $urandom_range(0, 99);
         if (r < 72) begin
            burst_kind = PAT_QUIET;
            burst_left = $urandom_range(1, 10);
         end else if (r < 82) begin
            burst_kind = PAT_VHIGH;
            burst_left = $urandom_range(1, 4);
         end else if (r < 90) begin
            burst_kind = PAT_OLOW;
            burst_left = $urandom_range(1, 4);
         end else if (r < 94) begin
            burst_kind = PAT_BOTH;
            burst_left = $urandom_range(1, 3);
         end else begin
            burst_kind = PAT_NOISE;
            burst_left = $urandom_range(1, 3);
         end
      end
      burst_left--;
      case (burst_kind)
         PAT_VHIGH: return HighTick;
         PAT_OLOW:  return LostTick;
         PAT_BOTH:  return BothTick;
         PAT_NOISE: return req_word_type'(2'($urandom_range(0, 3)));
         default:   return QuietTick;
      endcase
   endfunction

   task automatic csr_access(input bit is_write, input logic [2:0] idx,
                             input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic int reg_bits(input logic [2:0] idx);
      case (idx)
         REG_DEBOUNCE:    return 10;
         REG_SETTLE:      return 16;
         REG_CONFIRM:     return 8;
         REG_RELAY_GAP:   return 8;
         REG_RELAY_PULSE: return 12;
         REG_BLINK_HALF:  return 12;
         default:         return 4;
      endcase
   endfunction

   // drain all results and let the pipeline go quiet
   task automatic wait_drained();
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // load one timing setting, with junk above each register's width
   task automatic load_setting(input setting_type kind);
      logic [31:0] vals [RegCount];
      logic [31:0] junk;
      case (kind)
         SET_ZERO: begin
            foreach (vals[i]) vals[i] = '0;
         end
         SET_MAX: begin
            foreach (vals[i]) vals[i] = (32'd1 << reg_bits(3'(i))) - 1;
         end
         SET_FAST: begin
            vals[REG_DEBOUNCE]    = 2;
            vals[REG_SETTLE]      = 1;
            vals[REG_CONFIRM]     = 1;
            vals[REG_RELAY_GAP]   = 0;
            vals[REG_RELAY_PULSE] = 1;
            vals[REG_BLINK_HALF]  = 1;
            vals[REG_BLINK_COUNT] = 1;
         end
         default: begin
            vals[REG_DEBOUNCE]    = $urandom_range(1, 4);
            vals[REG_SETTLE]      = $urandom_range(0, 3);
            vals[REG_CONFIRM]     = $urandom_range(0, 3);
            vals[REG_RELAY_GAP]   = $urandom_range(0, 2);
            vals[REG_RELAY_PULSE] = $urandom_range(1, 4);
            vals[REG_BLINK_HALF]  = $urandom_range(1, 3);
            vals[REG_BLINK_COUNT] = (kind == SET_LONG_BLINK) ? 15 : $urandom_range(0, 3);
         end
      endcase
      for (int i = 0; i < RegCount; i++) begin
         junk = $urandom();
         csr_access(1'b1, 3'(i), (junk << reg_bits(3'(i))) | vals[i]);
      end
      for (int i = 0; i < RegCount; i++)
         csr_access(1'b0, 3'(i), '0);
   endtask

   initial begin
      setting_type plan [PhaseCount];
      plan = '{SET_SMALL, SET_ZERO, SET_SMALL, SET_MAX, SET_SMALL, SET_LONG_BLINK,
               SET_SMALL, SET_SMALL};

      // hold reset, then check reset values of the registers
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < RegCount; i++)
         csr_access(1'b0, 3'(i), '0);

      // every pin combination under the reset timing
      send_tick(BothTick);
      send_tick(LostTick);
      send_tick(HighTick);
      send_tick(QuietTick);
      req_valid <= 1'b0;
      wait_drained();

      // an address past the register list is ignored
      csr_access(1'b1, 3'(RegCount), $urandom());
      load_setting(SET_FAST);

      // walk to the on state, then lose output while overvoltage is unconfirmed
      send_ticks(QuietTick, 8);
      send_tick(BothTick);
      send_ticks(LostTick, 2);
      // walk up again, then trip on overvoltage and blink out
      send_ticks(QuietTick, 8);
      send_ticks(HighTick, 2);
      send_ticks(QuietTick, 3);
      req_valid <= 1'b0;

      // random sense patterns under each setting; setting changes only when idle
      foreach (plan[p]) begin
         wait_drained();
         load_setting(plan[p]);
         idling     = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         repeat (PhaseTicks) send_tick(next_sense_word());
         req_valid <= 1'b0;
      end

      idling = 1'b1;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_total == 0 && words_pending == 0)
         $display("tb_overvoltage_relay_sequencer OK");
      else
         $display("tb_overvoltage_relay_sequencer NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
src/ovrs_pkg.sv
src/ovrs_csr.sv
src/ovrs_core.sv
src/ovrs_skid.sv
src/overvoltage_relay_sequencer.sv
dv/ovrs_checker.sv
dv/tb_overvoltage_relay_sequencer.sv
